FILE: rtl/core/csfl_pkg.sv
// Package for the coalescing span free list unit.
// Holds the operation and status codes and the controller/datapath interface structs.
// No dependencies.
package csfl_pkg;

  localparam int unsigned FieldW = 32;

  typedef enum logic [1:0] {
    OP_FREE     = 2'd0,
    OP_ALLOC    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef struct packed {
    logic latch_in;
    logic clear;
    logic init_res;
    logic set_bad;
    logic rd_first;
    logic advance;
    logic merge_left;
    logic merge_right;
    logic drop;
    logic alloc_take;
    logic set_cov;
    logic move_wr;
    logic append;
    logic load_out;
  } ctl_t;

  typedef struct packed {
    op_e  op;
    logic bad;
    logic count_zero;
    logic idx_lt_count;
    logic next_lt_count;
    logic left_match;
    logic right_match;
    logic fits;
    logic size_zero_after;
    logic covers;
  } sts_t;

endpackage

FILE: rtl/core/csfl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csfl_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/csfl_ctrl.sv
// Controller state machine of the coalescing span free list unit.
// Depends on csfl_pkg for the command and status structs and the operation codes.
module csfl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  csfl_pkg::sts_t sts_i,
  output csfl_pkg::ctl_t ctl_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_MOVE   = 6'b001000,
    S_APPEND = 6'b010000,
    S_FIN    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   is_free;

  assign is_free     = (sts_i.op == csfl_pkg::OP_FREE);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch_in = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op == csfl_pkg::OP_CLEAR) begin
          ctl_o.clear = 1'b1;
          state_d     = S_FIN;
        end else if (sts_i.bad) begin
          ctl_o.set_bad = 1'b1;
          state_d       = S_FIN;
        end else begin
          ctl_o.init_res = 1'b1;
          if (sts_i.count_zero) begin
            state_d = is_free ? S_APPEND : S_FIN;
          end else begin
            ctl_o.rd_first = 1'b1;
            state_d        = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!sts_i.idx_lt_count) begin
          state_d = is_free ? S_APPEND : S_FIN;
        end else if (is_free && sts_i.left_match) begin
          ctl_o.merge_left = 1'b1;
          ctl_o.drop       = 1'b1;
          state_d          = S_MOVE;
        end else if (is_free && sts_i.right_match) begin
          ctl_o.merge_right = 1'b1;
          ctl_o.drop        = 1'b1;
          state_d           = S_MOVE;
        end else if (sts_i.op == csfl_pkg::OP_ALLOC && sts_i.fits) begin
          ctl_o.alloc_take = 1'b1;
          if (sts_i.size_zero_after) begin
            ctl_o.drop = 1'b1;
            state_d    = S_MOVE;
          end else begin
            state_d = S_FIN;
          end
        end else if (sts_i.op == csfl_pkg::OP_CONTAINS && sts_i.covers) begin
          ctl_o.set_cov = 1'b1;
          state_d       = S_FIN;
        end else if (sts_i.next_lt_count) begin
          ctl_o.advance = 1'b1;
        end else begin
          state_d = is_free ? S_APPEND : S_FIN;
        end
      end
      S_MOVE: begin
        ctl_o.move_wr = 1'b1;
        state_d       = is_free ? S_SCAN : S_FIN;
      end
      S_APPEND: begin
        ctl_o.append = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/csfl_dp.sv
// Datapath of the coalescing span free list unit: span table RAM, count, working
// range, scan index and result registers. Depends on csfl_pkg and csfl_ram.
module csfl_dp #(
  parameter int unsigned MaxSpans = 64,
  parameter int unsigned AddrBits = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  csfl_pkg::ctl_t                  ctl_i,
  output csfl_pkg::sts_t                  sts_o,
  input  logic [1:0]                      cmd_i,
  input  logic [csfl_pkg::FieldW-1:0]     req_start_i,
  input  logic [csfl_pkg::FieldW-1:0]     req_length_i,
  output logic [1:0]                      status_o,
  output logic [csfl_pkg::FieldW-1:0]     alloc_start_o,
  output logic                            covered_o
);

  localparam int unsigned W  = csfl_pkg::FieldW;
  localparam int unsigned AW = $clog2(MaxSpans);
  localparam int unsigned CW = $clog2(MaxSpans + 1);
  localparam logic [W:0] Limit = (AddrBits >= W) ? {1'b1, {W{1'b0}}}
                                                : ((W+1)'(1) << AddrBits);

  csfl_pkg::op_e     op_q;
  logic [W-1:0]      start_q, start_d;
  logic [W:0]        len_q, len_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     count_q, count_d;
  csfl_pkg::status_e res_status_q, res_status_d;
  logic [W-1:0]      res_astart_q, res_astart_d;
  logic              res_cov_q, res_cov_d;
  logic [1:0]        out_status_q;
  logic [W-1:0]      out_astart_q;
  logic              out_cov_q;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [2*W-1:0]    ram_wdata, ram_rdata;
  logic [W-1:0]      ent_begin, ent_size;
  logic [CW-1:0]     idx_next, count_dec;
  logic [W:0]        ent_end;
  logic [W+1:0]      req_end;
  logic [W+1:0]      len_sum;
  logic [W:0]        len_sat;
  logic              full;

  assign ent_begin = ram_rdata[W-1:0];
  assign ent_size  = ram_rdata[2*W-1:W];
  assign idx_next  = idx_q + CW'(1);
  assign count_dec = count_q - CW'(1);
  assign ent_end   = {1'b0, ent_begin} + {1'b0, ent_size};
  assign req_end   = {2'b0, start_q} + {1'b0, len_q};
  assign len_sum   = {1'b0, len_q} + {2'b0, ent_size};
  assign len_sat   = len_sum[W+1] ? {(W+1){1'b1}} : len_sum[W:0];
  assign full      = (count_q >= CW'(MaxSpans));

  always_comb begin
    sts_o                 = '0;
    sts_o.op              = op_q;
    sts_o.bad             = (len_q == '0) ||
                            ((op_q != csfl_pkg::OP_ALLOC) && (req_end[W:0] > Limit));
    sts_o.count_zero      = (count_q == '0);
    sts_o.idx_lt_count    = (idx_q < count_q);
    sts_o.next_lt_count   = (idx_next < count_q);
    sts_o.left_match      = (ent_end == {1'b0, start_q});
    sts_o.right_match     = (req_end == {2'b0, ent_begin});
    sts_o.fits            = ({1'b0, ent_size} >= len_q);
    sts_o.size_zero_after = (ent_size == len_q[W-1:0]);
    sts_o.covers          = (ent_begin <= start_q) && ({1'b0, ent_end} >= req_end);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_next[AW-1:0];
    if (ctl_i.alloc_take) begin
      ram_we    = 1'b1;
      ram_wdata = {ent_size - len_q[W-1:0], ent_begin + len_q[W-1:0]};
    end else if (ctl_i.move_wr) begin
      ram_we = 1'b1;
    end else if (ctl_i.append && !full) begin
      ram_we    = 1'b1;
      ram_waddr = count_q[AW-1:0];
      ram_wdata = {(len_q[W] ? {W{1'b1}} : len_q[W-1:0]), start_q};
    end
    if (ctl_i.rd_first) begin
      ram_re    = 1'b1;
      ram_raddr = '0;
    end else if (ctl_i.advance) begin
      ram_re = 1'b1;
    end else if (ctl_i.drop) begin
      ram_re    = 1'b1;
      ram_raddr = count_dec[AW-1:0];
    end
  end

  always_comb begin
    start_d      = start_q;
    len_d        = len_q;
    idx_d        = idx_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_astart_d = res_astart_q;
    res_cov_d    = res_cov_q;
    if (ctl_i.latch_in) begin
      start_d = req_start_i;
      len_d   = {1'b0, req_length_i};
    end
    if (ctl_i.merge_left) begin
      start_d = ent_begin;
    end
    if (ctl_i.merge_left || ctl_i.merge_right) begin
      len_d = len_sat;
    end
    if (ctl_i.rd_first) begin
      idx_d = '0;
    end else if (ctl_i.advance) begin
      idx_d = idx_next;
    end
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (ctl_i.drop) begin
      count_d = count_dec;
    end else if (ctl_i.append && !full) begin
      count_d = count_q + CW'(1);
    end
    if (ctl_i.clear || ctl_i.set_bad || ctl_i.init_res) begin
      res_astart_d = '0;
      res_cov_d    = 1'b0;
      res_status_d = csfl_pkg::ST_OK;
      if (ctl_i.set_bad) begin
        res_status_d = csfl_pkg::ST_BAD;
      end else if (ctl_i.init_res && op_q == csfl_pkg::OP_ALLOC) begin
        res_status_d = csfl_pkg::ST_NOFIT;
      end
    end
    if (ctl_i.alloc_take) begin
      res_astart_d = ent_begin;
      res_status_d = csfl_pkg::ST_OK;
    end
    if (ctl_i.set_cov) begin
      res_cov_d = 1'b1;
    end
    if (ctl_i.append && full) begin
      res_status_d = csfl_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      op_q <= csfl_pkg::op_e'(cmd_i);
    end
    start_q      <= start_d;
    len_q        <= len_d;
    idx_q        <= idx_d;
    res_status_q <= res_status_d;
    res_astart_q <= res_astart_d;
    res_cov_q    <= res_cov_d;
    if (ctl_i.load_out) begin
      out_status_q <= res_status_q;
      out_astart_q <= res_astart_q;
      out_cov_q    <= res_cov_q;
    end
  end

  assign status_o      = out_status_q;
  assign alloc_start_o = out_astart_q;
  assign covered_o     = out_cov_q;

  csfl_ram #(
    .Width (2 * W),
    .Depth (MaxSpans)
  ) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: rtl/core/coalescing_span_free_list_unit.sv
// Coalescing span free list: first-fit allocator over a table of free extents.
// An item passes from acceptance through decode, one scan step per table read, one move step
// per entry removed and, for a free, an append step, and then to the result stage.
// The result is loaded once the previous one has left the output register, and the next
// item is accepted from the cycle after that. Reset empties the table at once.
// Depends on csfl_pkg, csfl_ctrl and csfl_dp.
module coalescing_span_free_list_unit #(
  parameter int unsigned MaxSpans = 64,
  parameter int unsigned AddrBits = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // req_start, req_length
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // alloc_start, covered, zero fill
  output logic [1:0]  m_axis_tuser    // status
);

  csfl_pkg::ctl_t              ctl;
  csfl_pkg::sts_t              sts;
  logic [csfl_pkg::FieldW-1:0] alloc_start;
  logic                        covered;

  csfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  csfl_dp #(
    .MaxSpans (MaxSpans),
    .AddrBits (AddrBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cmd_i         (s_axis_tuser),
    .req_start_i   (s_axis_tdata[31:0]),
    .req_length_i  (s_axis_tdata[63:32]),
    .status_o      (m_axis_tuser),
    .alloc_start_o (alloc_start),
    .covered_o     (covered)
  );

  assign m_axis_tdata = {7'b0, covered, alloc_start};

endmodule

FILE: sim/coalescing_span_free_list_checker.sv
// Checker for the coalescing span free list unit: keeps its own copy of the free extent
// table, predicts the result of every accepted request and compares the results on the output.
// Depends on csfl_pkg.
`timescale 1ns / 100ps

module coalescing_span_free_list_checker
  import csfl_pkg::*;
#(
  parameter int unsigned MaxSpans = 64,
  parameter int unsigned AddrBits = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // req_start, req_length
  input  logic [1:0]  s_axis_tuser,   // cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // alloc_start, covered, zero fill
  input  logic [1:0]  m_axis_tuser,   // status
  output int unsigned results_due_o,
  output int unsigned mismatch_count_o
);

  localparam logic [63:0] AddrLimit =
      (AddrBits >= 32) ? 64'h1_0000_0000 : (64'd1 << AddrBits);

  typedef struct packed {
    status_e     status;
    logic [31:0] alloc_start;
    logic        covered;
  } span_reply_t;

  logic [31:0] span_base [MaxSpans];
  logic [31:0] span_len  [MaxSpans];
  int unsigned span_total = 0;
  span_reply_t span_replies [$];
  int unsigned fault_total = 0;

  // The last entry moves into the freed slot, so the caller must look at that slot again.
  function automatic void drop_span(int unsigned idx);
    span_total--;
    span_base[idx] = span_base[span_total];
    span_len[idx]  = span_len[span_total];
  endfunction

  function automatic span_reply_t apply_span_op(op_e op, logic [31:0] start,
                                                logic [31:0] len);
    span_reply_t reply;
    logic [63:0] lo;
    logic [63:0] sz;
    int unsigned idx;
    reply = '{status: ST_OK, alloc_start: 32'd0, covered: 1'b0};
    lo    = {32'd0, start};
    sz    = {32'd0, len};
    idx   = 0;
    if (op == OP_CLEAR) begin
      span_total = 0;
    end else if (len == 32'd0) begin
      reply.status = ST_BAD;
    end else if (op == OP_ALLOC) begin
      reply.status = ST_NOFIT;
      while (idx < span_total && reply.status == ST_NOFIT) begin
        if (span_len[idx] >= len) begin
          reply.status      = ST_OK;
          reply.alloc_start = span_base[idx];
          span_len[idx]     = span_len[idx] - len;
          span_base[idx]    = span_base[idx] + len;
          if (span_len[idx] == 32'd0) drop_span(idx);
        end
        idx++;
      end
    end else if (lo + sz > AddrLimit) begin
      reply.status = ST_BAD;
    end else if (op == OP_FREE) begin
      while (idx < span_total) begin
        if ({32'd0, span_base[idx]} + span_len[idx] == lo) begin
          lo = {32'd0, span_base[idx]};
          sz = sz + span_len[idx];
          drop_span(idx);
        end else if ({32'd0, span_base[idx]} == lo + sz) begin
          sz = sz + span_len[idx];
          drop_span(idx);
        end else begin
          idx++;
        end
      end
      if (span_total >= MaxSpans) begin
        reply.status = ST_FULL;
      end else begin
        span_base[span_total] = lo[31:0];
        span_len[span_total]  = (sz > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sz[31:0];
        span_total++;
      end
    end else begin
      while (idx < span_total && !reply.covered) begin
        if ({32'd0, span_base[idx]} <= lo &&
            {32'd0, span_base[idx]} + span_len[idx] >= lo + sz) begin
          reply.covered = 1'b1;
        end
        idx++;
      end
    end
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    span_reply_t want;
    if (!rst_ni) begin
      span_total = 0;
      span_replies.delete();
      results_due_o    <= 0;
      mismatch_count_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (span_replies.size() == 0) begin
          $error("result item with no expectation: status %0d", m_axis_tuser);
          fault_total++;
        end else begin
          want = span_replies.pop_front();
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            fault_total++;
          end
          if (m_axis_tdata[31:0] !== want.alloc_start) begin
            $error("alloc_start: expected %0h, actual %0h", want.alloc_start,
                   m_axis_tdata[31:0]);
            fault_total++;
          end
          if (m_axis_tdata[32] !== want.covered) begin
            $error("covered: expected %0d, actual %0d", want.covered, m_axis_tdata[32]);
            fault_total++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        span_replies.push_back(apply_span_op(op_e'(s_axis_tuser), s_axis_tdata[31:0],
                                             s_axis_tdata[63:32]));
      end
      results_due_o    <= span_replies.size();
      mismatch_count_o <= fault_total;
    end
  end

endmodule

FILE: sim/coalescing_span_free_list_unit_tb.sv
// Top of the testbench for the coalescing span free list unit: clock, reset, request
// stimulus with random idling on both sides, and the final verdict.
// Depends on csfl_pkg, coalescing_span_free_list_unit and coalescing_span_free_list_checker.
`timescale 1ns / 100ps

module coalescing_span_free_list_unit_tb;
  import csfl_pkg::*;

  localparam int unsigned MaxSpans    = 64;
  localparam int unsigned AddrBits    = 32;
  localparam int unsigned GridUnit    = 16;
  localparam int unsigned PhaseItems  = 80;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned CycleLimit  = 1000000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = OP_CLEAR;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned cycle_count = 0;
  int unsigned results_due;
  int unsigned mismatch_count;

  coalescing_span_free_list_unit #(
    .MaxSpans(MaxSpans),
    .AddrBits(AddrBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  coalescing_span_free_list_checker #(
    .MaxSpans(MaxSpans),
    .AddrBits(AddrBits)
  ) span_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .results_due_o   (results_due),
    .mismatch_count_o(mismatch_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[coalescing_span_free_list_unit] ERROR");
      $finish;
    end
  end

  // The valid stays high from one item to the next unless a gap is drawn.
  task automatic issue_request(op_e op, logic [31:0] start, logic [31:0] len);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {len, start};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_due != 0);
  endtask

  // Fills the table with isolated extents, overflows it, then merges into a full table.
  task automatic fill_table();
    int unsigned k;
    issue_request(OP_CLEAR, 32'd0, 32'd0);
    for (k = 0; k <= MaxSpans; k++) begin
      issue_request(OP_FREE, 32'h0010_0000 + k * 8, $urandom_range(1, 6));
    end
    issue_request(OP_FREE, 32'h000F_FFFF, 32'd1);
    issue_request(OP_FREE, 32'h0020_0000, 32'd1);
    issue_request(OP_CONTAINS, 32'h000F_FFFF, 32'd2);
    issue_request(OP_ALLOC, 32'd0, 32'd3);
  endtask

  task automatic issue_random_request();
    int unsigned pick;
    logic [31:0] base;
    logic [31:0] start;
    logic [31:0] len;
    op_e         op;
    pick = $urandom_range(99);
    case ($urandom_range(3))
      0, 1: base = 32'h0000_0000;
      2: base = 32'h7FFF_F000;
      default: base = 32'hFFFF_FD00;
    endcase
    start = base + $urandom_range(47) * GridUnit;
    len   = $urandom_range(1, 4) * GridUnit;
    if ($urandom_range(9) == 0) len = $urandom_range(1, 5 * GridUnit);
    op = OP_FREE;
    if (pick < 38) begin
      op = OP_FREE;
    end else if (pick < 60) begin
      op  = OP_ALLOC;
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 3 * GridUnit)
                                     : $urandom_range(1, 5) * GridUnit;
    end else if (pick < 78) begin
      op    = OP_CONTAINS;
      start = start + $urandom_range(GridUnit - 1);
      len   = $urandom_range(1, 3 * GridUnit);
    end else if (pick < 82) begin
      op = OP_CLEAR;
    end else if (pick < 94) begin
      op    = op_e'($urandom_range(3));
      start = $urandom;
      len   = $urandom;
      if ($urandom_range(1) == 1) len = len >> $urandom_range(31);
    end else begin
      op  = op_e'($urandom_range(2));
      len = 32'd0;
    end
    issue_request(op, start, len);
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue_request(OP_CONTAINS, 32'd0, 32'd1);
    issue_request(OP_ALLOC, 32'd0, 32'd1);
    issue_request(OP_FREE, 32'd64, 32'd0);
    issue_request(OP_ALLOC, 32'd0, 32'd0);
    issue_request(OP_CONTAINS, 32'd64, 32'd0);
    issue_request(OP_FREE, 32'hFFFF_FFFF, 32'd2);
    issue_request(OP_CONTAINS, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    issue_request(OP_FREE, 32'hFFFF_FFFF, 32'd1);
    issue_request(OP_FREE, 32'd100, 32'd10);
    issue_request(OP_FREE, 32'd120, 32'd10);
    issue_request(OP_FREE, 32'd110, 32'd10);
    issue_request(OP_CONTAINS, 32'd100, 32'd30);
    issue_request(OP_CONTAINS, 32'd99, 32'd2);
    issue_request(OP_ALLOC, 32'd0, 32'd30);
    issue_request(OP_ALLOC, 32'd0, 32'd1);
    issue_request(OP_FREE, 32'd0, 32'h8000_0000);
    issue_request(OP_FREE, 32'h8000_0000, 32'h8000_0000);
    issue_request(OP_CONTAINS, 32'd0, 32'hFFFF_FFFF);
    issue_request(OP_ALLOC, 32'd0, 32'hFFFF_FFFF);
    issue_request(OP_ALLOC, 32'd0, 32'd1);
    issue_request(OP_FREE, 32'd5, 32'd5);
    issue_request(OP_ALLOC, 32'd0, 32'd3);
    issue_request(OP_ALLOC, 32'd0, 32'd5);
    issue_request(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_request(OP_CONTAINS, 32'd8, 32'd1);

    for (phase = 0; phase < 4; phase++) begin
      wait_results_drained();
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 59;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 59;
        end
        default: begin
          idle_pct  = 9;
          stall_pct = 9;
        end
      endcase
      if (phase == 1 || phase == 3) fill_table();
      for (n = 0; n < PhaseItems; n++) issue_random_request();
    end

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[coalescing_span_free_list_unit] OK");
    end else begin
      $display("[coalescing_span_free_list_unit] ERROR");
    end
    $finish;
  end

endmodule
